### hw/rtl/mlbrf_pkg.sv
`timescale 1ns / 1ps

package mlbrf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned MODE_W     = 3;
  // byte fields carried by one item
  localparam int unsigned NUM_FIELDS = 4;
  // storage is interleaved over this many banks, address modulo NUM_BANKS
  localparam int unsigned NUM_BANKS  = 4;
  localparam int unsigned BANK_SEL_W = 2;
  localparam int unsigned LANE_IDX_W = 3;

  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SKIP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

### hw/rtl/mlbrf_if.sv
`timescale 1ns / 1ps

interface mlbrf_item_if import mlbrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  cnt_t              amount;
  byte_t             in_byte0;
  byte_t             in_byte1;
  byte_t             in_byte2;
  byte_t             in_byte3;

  modport source (
    output valid, mode, amount, in_byte0, in_byte1, in_byte2, in_byte3,
    input  ready
  );
  modport sink (
    input  valid, mode, amount, in_byte0, in_byte1, in_byte2, in_byte3,
    output ready
  );
endinterface

interface mlbrf_result_if import mlbrf_pkg::*; ();
  logic  valid;
  logic  ready;
  cnt_t  done_count;
  byte_t out_byte0;
  byte_t out_byte1;
  byte_t out_byte2;
  byte_t out_byte3;
  cnt_t  used_bytes;
  cnt_t  free_bytes;

  modport source (
    output valid, done_count, out_byte0, out_byte1, out_byte2, out_byte3,
           used_bytes, free_bytes,
    input  ready
  );
  modport sink (
    input  valid, done_count, out_byte0, out_byte1, out_byte2, out_byte3,
           used_bytes, free_bytes,
    output ready
  );
endinterface

### hw/rtl/mlbrf_bank.sv
`timescale 1ns / 1ps

// One storage bank: single port, registered read data.
module mlbrf_bank import mlbrf_pkg::*; #(
  parameter int unsigned ROWS = 256,
  parameter int unsigned RW   = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [RW-1:0] addr_i,
  input  byte_t         wdata_i,
  output byte_t         rdata_o
);

  byte_t mem_q [ROWS];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/multi_lane_byte_ring_fifo.sv
`timescale 1ns / 1ps
// Sequencing: an accepted item walks two bank passes, a read capture and a result load
//   (ST_PASS0, ST_PASS1, ST_CAPT, ST_DONE) over four single-port byte banks; ST_DONE
//   waits while the held result is not taken, and no new item is accepted until then.
// Reset: rst_ni clears head/tail pointers, sequencer and result valid; the byte
//   banks are not cleared and hold garbage until written.
module multi_lane_byte_ring_fifo import mlbrf_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned LANES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mlbrf_item_if.sink            item_i,
  mlbrf_result_if.source        result_o
);

  // ------------------------------------------------------------------
  // Sizing
  // ------------------------------------------------------------------
  localparam int unsigned IW        = $clog2(DEPTH);          // pointer width
  localparam int unsigned SW        = ((IW > CNT_W) ? IW : CNT_W) + 1;  // arithmetic width
  localparam int unsigned LC        = (LANES < NUM_FIELDS) ? LANES : NUM_FIELDS;
  localparam int unsigned BANK_ROWS = (DEPTH + NUM_BANKS - 1) / NUM_BANKS;
  localparam int unsigned RW        = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PASS0 = 3'd1;  // bank access up to the wrap point
  localparam logic [2:0] ST_PASS1 = 3'd2;  // bank access after the wrap
  localparam logic [2:0] ST_CAPT  = 3'd3;  // last read data lands, pointers move
  localparam logic [2:0] ST_DONE  = 3'd4;  // load result register

  logic [2:0]         state_q, state_d;
  logic [IW-1:0]      head_q, head_d;
  logic [IW-1:0]      tail_q, tail_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  cnt_t               done_q, done_d;
  logic [IW-1:0]      base_q, base_d;
  logic [LANE_IDX_W-1:0] cnt0_q, cnt0_d;
  byte_t              wbyte_q [NUM_FIELDS];
  byte_t              wbyte_d [NUM_FIELDS];
  byte_t              rbyte_q [NUM_FIELDS];
  byte_t              rbyte_d [NUM_FIELDS];
  logic [NUM_BANKS-1:0]  rd_pend_q, rd_pend_d;
  logic [BANK_SEL_W-1:0] rd_dst_q [NUM_BANKS];
  logic [BANK_SEL_W-1:0] rd_dst_d [NUM_BANKS];

  logic               out_valid_q, out_valid_d;
  cnt_t               res_done_q, res_done_d;
  byte_t              res_byte_q [NUM_FIELDS];
  byte_t              res_byte_d [NUM_FIELDS];
  cnt_t               res_used_q, res_used_d;
  cnt_t               res_free_q, res_free_d;

  logic               accept;
  logic               load_res;

  // ------------------------------------------------------------------
  // Fill level, shared by the request clip and the result
  // ------------------------------------------------------------------
  logic [SW-1:0] used_w, space_w, amt_w, lim_w, done_w;

  always_comb begin
    if (tail_q >= head_q) begin
      used_w = SW'(tail_q) - SW'(head_q);
    end else begin
      used_w = SW'(tail_q) + SW'(DEPTH) - SW'(head_q);
    end
    space_w = SW'(DEPTH - 1) - used_w;
    amt_w   = SW'(item_i.amount);
    lim_w   = (amt_w < SW'(LC)) ? amt_w : SW'(LC);
    unique case (item_i.mode)
      MODE_WRITE:            done_w = (lim_w < space_w) ? lim_w : space_w;
      MODE_READ, MODE_PEEK:  done_w = (lim_w < used_w) ? lim_w : used_w;
      MODE_SKIP:             done_w = (amt_w < used_w) ? amt_w : used_w;
      default:               done_w = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Bank lanes: each pass touches consecutive addresses without a wrap,
  // so the four byte positions always fall in distinct banks.
  // ------------------------------------------------------------------
  logic                  rw_op;
  logic                  is_pass;
  logic [IW-1:0]         p_a0;
  logic [LANE_IDX_W-1:0] p_off, p_cnt;
  logic [SW-1:0]         room_w;
  logic [LANE_IDX_W-1:0] cnt0_w;

  logic [NUM_BANKS-1:0]  bk_en;
  logic                  bk_we;
  logic [RW-1:0]         bk_row   [NUM_BANKS];
  byte_t                 bk_wdata [NUM_BANKS];
  byte_t                 bk_rdata [NUM_BANKS];
  logic [BANK_SEL_W-1:0] bk_dst   [NUM_BANKS];

  assign rw_op = (mode_q == MODE_WRITE) || (mode_q == MODE_READ) || (mode_q == MODE_PEEK);
  assign bk_we = (mode_q == MODE_WRITE);

  always_comb begin
    room_w = SW'(DEPTH) - SW'(base_q);
    cnt0_w = (room_w < SW'(done_q)) ? room_w[LANE_IDX_W-1:0] : done_q[LANE_IDX_W-1:0];
    is_pass = (state_q == ST_PASS0) || (state_q == ST_PASS1);
    if (state_q == ST_PASS1) begin
      p_a0  = '0;
      p_off = cnt0_q;
      p_cnt = done_q[LANE_IDX_W-1:0] - cnt0_q;
    end else begin
      p_a0  = base_q;
      p_off = '0;
      p_cnt = cnt0_w;
    end
  end

  always_comb begin
    logic [BANK_SEL_W-1:0] j;
    logic [SW-1:0]         addr;
    logic [LANE_IDX_W-1:0] idx;
    for (int b = 0; b < NUM_BANKS; b++) begin
      j           = BANK_SEL_W'(b) - p_a0[BANK_SEL_W-1:0];
      addr        = SW'(p_a0) + SW'(j);
      idx         = p_off + LANE_IDX_W'(j);
      bk_en[b]    = is_pass && rw_op && (LANE_IDX_W'(j) < p_cnt);
      bk_row[b]   = RW'(addr >> BANK_SEL_W);
      bk_wdata[b] = wbyte_q[idx[BANK_SEL_W-1:0]];
      bk_dst[b]   = idx[BANK_SEL_W-1:0];
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    mlbrf_bank #(
      .ROWS (BANK_ROWS),
      .RW   (RW)
    ) u_bank (
      .clk_i   (clk_i),
      .en_i    (bk_en[b]),
      .we_i    (bk_we),
      .addr_i  (bk_row[b]),
      .wdata_i (bk_wdata[b]),
      .rdata_o (bk_rdata[b])
    );
  end

  // ------------------------------------------------------------------
  // Sequencer, read merge and pointer update
  // ------------------------------------------------------------------
  logic [SW-1:0] ptr_sum;

  assign accept   = item_i.valid && item_i.ready;
  assign load_res = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    mode_d      = mode_q;
    done_d      = done_q;
    base_d      = base_q;
    cnt0_d      = cnt0_q;
    wbyte_d     = wbyte_q;
    rbyte_d     = rbyte_q;
    out_valid_d = out_valid_q;
    res_done_d  = res_done_q;
    res_byte_d  = res_byte_q;
    res_used_d  = res_used_q;
    res_free_d  = res_free_q;
    ptr_sum     = '0;

    // read data from the previous pass lands in its byte slot
    for (int b = 0; b < NUM_BANKS; b++) begin
      rd_pend_d[b] = bk_en[b] && !bk_we;
      rd_dst_d[b]  = bk_dst[b];
    end
    for (int s = 0; s < NUM_FIELDS; s++) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        if (rd_pend_q[b] && (rd_dst_q[b] == BANK_SEL_W'(s))) begin
          rbyte_d[s] = bk_rdata[b];
        end
      end
    end

    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d     = item_i.mode;
          done_d     = done_w[CNT_W-1:0];
          base_d     = (item_i.mode == MODE_WRITE) ? tail_q : head_q;
          wbyte_d[0] = item_i.in_byte0;
          wbyte_d[1] = item_i.in_byte1;
          wbyte_d[2] = item_i.in_byte2;
          wbyte_d[3] = item_i.in_byte3;
          for (int s = 0; s < NUM_FIELDS; s++) begin
            rbyte_d[s] = '0;
          end
          state_d = ST_PASS0;
        end
      end
      ST_PASS0: begin
        cnt0_d  = cnt0_w;
        state_d = ST_PASS1;
      end
      ST_PASS1: begin
        state_d = ST_CAPT;
      end
      ST_CAPT: begin
        ptr_sum = ((mode_q == MODE_WRITE) ? SW'(tail_q) : SW'(head_q)) + SW'(done_q);
        if (ptr_sum >= SW'(DEPTH)) begin
          ptr_sum = ptr_sum - SW'(DEPTH);
        end
        unique case (mode_q)
          MODE_WRITE:           tail_d = ptr_sum[IW-1:0];
          MODE_READ, MODE_SKIP: head_d = ptr_sum[IW-1:0];
          MODE_CLEAR: begin
            head_d = '0;
            tail_d = '0;
          end
          default: ;
        endcase
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_res) begin
          out_valid_d = 1'b1;
          res_done_d  = done_q;
          res_byte_d  = rbyte_q;
          res_used_d  = used_w[CNT_W-1:0];
          res_free_d  = space_w[CNT_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
      rd_pend_q   <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    done_q     <= done_d;
    base_q     <= base_d;
    cnt0_q     <= cnt0_d;
    wbyte_q    <= wbyte_d;
    rbyte_q    <= rbyte_d;
    rd_dst_q   <= rd_dst_d;
    res_done_q <= res_done_d;
    res_byte_q <= res_byte_d;
    res_used_q <= res_used_d;
    res_free_q <= res_free_d;
  end

  // ------------------------------------------------------------------
  // Ports
  // ------------------------------------------------------------------
  assign item_i.ready        = (state_q == ST_IDLE);
  assign result_o.valid      = out_valid_q;
  assign result_o.done_count = res_done_q;
  assign result_o.out_byte0  = res_byte_q[0];
  assign result_o.out_byte1  = res_byte_q[1];
  assign result_o.out_byte2  = res_byte_q[2];
  assign result_o.out_byte3  = res_byte_q[3];
  assign result_o.used_bytes = res_used_q;
  assign result_o.free_bytes = res_free_q;

endmodule
